// File: rtl/core/lsh_pkg.sv
// ---------------------------------------------------------------------------
// lsh_pkg: shared types and constants for the 3x3 Laplacian sharpener
// Word layouts for both channels, the group descriptor passed to the
// result sequencer, register indexes and reset values.
// ---------------------------------------------------------------------------
package lsh_pkg;

  localparam int SAMP_W    = 8;
  localparam int NUM_SLOTS = 4;    // channel fields carried by one word
  localparam int ROW_W     = 12;
  localparam int COL_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CHAN_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  // register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [2:0]  CHAN_RST   = 3'd3;

  localparam int MIN_DIM     = 3;
  localparam int CENTER_GAIN = 5;
  localparam int PIX_MAX     = 255;

  typedef logic [SAMP_W-1:0] samp_t;

  typedef struct packed {
    samp_t sample_0;
    samp_t sample_1;
    samp_t sample_2;
    samp_t sample_3;
  } in_word_t;

  typedef struct packed {
    samp_t             result_0;
    samp_t             result_1;
    samp_t             result_2;
    samp_t             result_3;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              last_of_run;
  } out_word_t;

  // position of the input pixel that caused a result group
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_row;
    logic             last_col;
  } grp_t;

endpackage

// File: rtl/core/lsh_ram.sv
// ---------------------------------------------------------------------------
// lsh_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/lsh_lane.sv
// ---------------------------------------------------------------------------
// lsh_lane: one channel of the sharpening kernel
// 5*center minus the left, right, up and down neighbors, clamped to 0..255; zero when off.
// ---------------------------------------------------------------------------
module lsh_lane (
  input  lsh_pkg::samp_t center,
  input  lsh_pkg::samp_t left,
  input  lsh_pkg::samp_t right,
  input  lsh_pkg::samp_t up,
  input  lsh_pkg::samp_t down,
  input  logic           en,
  output lsh_pkg::samp_t res
);

  logic [10:0]        gain;
  logic [9:0]         nsum;
  logic signed [11:0] diff;

  always_comb begin
    gain = 11'(center) * 11'(lsh_pkg::CENTER_GAIN);
    nsum = 10'(left) + 10'(right) + 10'(up) + 10'(down);
    diff = $signed({1'b0, gain}) - $signed({2'b00, nsum});
    if (!en || diff < 12'sd0) begin
      res = '0;
    end else if (diff > 12'(lsh_pkg::PIX_MAX)) begin
      res = lsh_pkg::samp_t'(lsh_pkg::PIX_MAX);
    end else begin
      res = diff[7:0];
    end
  end

endmodule

// File: rtl/core/lsh_emit.sv
// ---------------------------------------------------------------------------
// lsh_emit: result merge and sequencer
// Captures the lane results of one input and sends its one, two or four
// result words, the first carrying the lanes, the rest the zero border.
// ---------------------------------------------------------------------------
module lsh_emit (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           load,
  input  lsh_pkg::grp_t                                  grp,
  input  logic [lsh_pkg::NUM_SLOTS-1:0][lsh_pkg::SAMP_W-1:0] lane_res,
  output logic                                           ready,
  output logic                                           out_valid,
  input  logic                                           out_stall,
  output lsh_pkg::out_word_t                             out_data
);

  logic                                               b_valid_r, b_valid_nxt;
  logic [1:0]                                         b_idx_r, b_idx_nxt;
  lsh_pkg::grp_t                                      b_grp_r;
  logic [lsh_pkg::NUM_SLOTS-1:0][lsh_pkg::SAMP_W-1:0] b_res_r;

  logic       out_acc;
  logic [1:0] last_idx;
  logic       is_last;
  logic       done;
  logic       row_sel;
  logic       col_sel;
  logic       first;

  always_comb begin
    last_idx = {b_grp_r.last_row & b_grp_r.last_col,
                b_grp_r.last_row | b_grp_r.last_col};
    is_last  = (b_idx_r == last_idx);
    out_acc  = b_valid_r && !out_stall;
    done     = out_acc && is_last;
    ready    = !b_valid_r || done;
    // bottom row after the current one, last column after the current one
    row_sel  = b_grp_r.last_row & b_idx_r[0];
    col_sel  = b_grp_r.last_row ? (b_grp_r.last_col & b_idx_r[1])
                                : (b_grp_r.last_col & b_idx_r[0]);
    first    = (b_idx_r == 2'd0);
  end

  always_comb begin
    out_valid            = b_valid_r;
    out_data.result_0    = first ? b_res_r[0] : '0;
    out_data.result_1    = first ? b_res_r[1] : '0;
    out_data.result_2    = first ? b_res_r[2] : '0;
    out_data.result_3    = first ? b_res_r[3] : '0;
    out_data.out_row     = row_sel ? b_grp_r.row : b_grp_r.row - 12'd1;
    out_data.out_col     = col_sel ? b_grp_r.col : b_grp_r.col - 11'd1;
    out_data.last_of_run = is_last;
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    b_idx_nxt   = b_idx_r;
    if (load) begin
      b_valid_nxt = 1'b1;
      b_idx_nxt   = 2'd0;
    end else if (done) begin
      b_valid_nxt = 1'b0;
    end else if (out_acc) begin
      b_idx_nxt   = b_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_idx_r   <= 2'd0;
    end else begin
      b_valid_r <= b_valid_nxt;
      b_idx_r   <= b_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_grp_r <= grp;
      b_res_r <= lane_res;
    end
  end

endmodule

// File: rtl/core/laplacian_sharpen_3x3.sv
// ---------------------------------------------------------------------------
// laplacian_sharpen_3x3: streaming 3x3 Laplacian sharpening filter
// Raster pixels of up to four 8-bit channels in; per channel
// 5*center - left - right - up - down, clamped, out, one row and one
// column behind the input, with the output pixel's own row and column.
// ---------------------------------------------------------------------------
//
//  port group   dir  word            handshake
//  ----------   ---  --------------  ---------------------------------
//  in_*         in   in_word_t       in_valid / in_stall
//  out_*        out  out_word_t      out_valid / out_stall
//  cfg_*        in   12-bit data     cfg_we, index 0 width, 1 height,
//                                    2 channel count
//
// One pixel word per clock while in_stall is low; the word is registered in
// stage A and its results in the output sequencer. Row 0 and column 0 give
// no result; other pixels give one word, two on the last column or last
// row, four for the last pixel of the last row, sent by the sequencer one
// per cycle while out_stall is low. Reset is synchronous; line memories are
// not cleared, stale entries only feed border results (forced zero). The
// read stage raises in_stall only while the sequencer cannot take its group.
// ---------------------------------------------------------------------------
module laplacian_sharpen_3x3 #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lsh_pkg::in_word_t                 in_data,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output lsh_pkg::out_word_t                out_data,
  // register writes
  input  logic                              cfg_we,
  input  logic [lsh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1; // column address
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > lsh_pkg::CFG_DATA_W) ? WW : lsh_pkg::CFG_DATA_W;
  localparam int PW = lsh_pkg::SAMP_W * MAX_CHANNELS;          // packed pixel
  localparam int RW = lsh_pkg::ROW_W;

  // ---- configuration registers ----
  logic [11:0]              cfg_width_r;
  logic [11:0]              cfg_height_r;
  logic [lsh_pkg::CHAN_W-1:0] cfg_chan_r;
  logic                     geom_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= lsh_pkg::WIDTH_RST;
      cfg_height_r <= lsh_pkg::HEIGHT_RST;
      cfg_chan_r   <= lsh_pkg::CHAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsh_pkg::CFG_IMAGE_WIDTH:   cfg_width_r  <= cfg_data;
        lsh_pkg::CFG_IMAGE_HEIGHT:  cfg_height_r <= cfg_data;
        lsh_pkg::CFG_CHANNEL_COUNT: cfg_chan_r   <= cfg_data[lsh_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // width/height writes restart the frame
  assign geom_wr = cfg_we && (cfg_index == lsh_pkg::CFG_IMAGE_WIDTH ||
                              cfg_index == lsh_pkg::CFG_IMAGE_HEIGHT);

  // ---- effective geometry: width 3..MAX_WIDTH, height >= 3, channels 1..MAX ----
  logic [EW-1:0]              w_ext, w_last;
  logic [RW-1:0]              h_last;
  logic [lsh_pkg::CHAN_W-1:0] ch_eff;

  always_comb begin
    w_ext = EW'(cfg_width_r);
    if (w_ext < EW'(lsh_pkg::MIN_DIM)) begin
      w_ext = EW'(lsh_pkg::MIN_DIM);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_ext = EW'(MAX_WIDTH);
    end
    w_last = w_ext - EW'(1);

    if (cfg_height_r < RW'(lsh_pkg::MIN_DIM)) begin
      h_last = RW'(lsh_pkg::MIN_DIM - 1);
    end else begin
      h_last = cfg_height_r - RW'(1);
    end

    if (cfg_chan_r == '0) begin
      ch_eff = lsh_pkg::CHAN_W'(1);
    end else if (cfg_chan_r > lsh_pkg::CHAN_W'(MAX_CHANNELS)) begin
      ch_eff = lsh_pkg::CHAN_W'(MAX_CHANNELS);
    end else begin
      ch_eff = cfg_chan_r;
    end
  end

  // ---- position of the next input pixel ----
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          in_acc;
  logic          at_last_col;
  logic          at_last_row;

  assign in_acc      = in_valid && !in_stall;
  assign at_last_col = (EW'(col_r) == w_last);
  assign at_last_row = (row_r >= h_last);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geom_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_acc) begin
      if (at_last_col) begin
        col_nxt = '0;
        row_nxt = at_last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---- stage A: line memory read in flight ----
  logic          a_valid_r;
  logic [PW-1:0] a_px_r;
  logic [CW-1:0] a_col_r;
  logic          a_emit_r;       // input has row >= 1 and col >= 1
  logic          a_int_r;        // output pixel is interior
  lsh_pkg::grp_t a_grp_r;
  logic          a_move;
  logic          emit_ready;
  logic [PW-1:0] in_px;

  lsh_pkg::samp_t in_samp [lsh_pkg::NUM_SLOTS];

  assign in_samp[0] = in_data.sample_0;
  assign in_samp[1] = in_data.sample_1;
  assign in_samp[2] = in_data.sample_2;
  assign in_samp[3] = in_data.sample_3;

  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_pack
    assign in_px[k*lsh_pkg::SAMP_W +: lsh_pkg::SAMP_W] = in_samp[k];
  end

  assign a_move   = a_valid_r && (emit_ready || !a_emit_r);
  assign in_stall = a_valid_r && !a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px_r            <= in_px;
      a_col_r           <= col_r;
      a_emit_r          <= (row_r != '0) && (col_r != '0);
      a_int_r           <= (row_r >= RW'(2)) && (col_r >= CW'(2));
      a_grp_r.row       <= row_r;
      a_grp_r.col       <= lsh_pkg::COL_W'(col_r);
      a_grp_r.last_row  <= at_last_row;
      a_grp_r.last_col  <= at_last_col;
    end
  end

  // ---- line memories: rows r-2 and r-1 ----
  logic [PW-1:0] above_q;
  logic [PW-1:0] cur_q;

  lsh_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (a_move),
    .waddr (a_col_r),
    .wdata (cur_q),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (above_q)
  );

  lsh_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_cur (
    .clk   (clk),
    .we    (a_move),
    .waddr (a_col_r),
    .wdata (a_px_r),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (cur_q)
  );

  // ---- window: only the taps the kernel reads are kept ----
  // up_r:   row above, newest column (becomes up of next center)
  // mid1_r: middle row, column before the newest; mid2_r: middle row, newest column
  // dn_r:   incoming row, newest column
  logic [PW-1:0] up_r, mid1_r, mid2_r, dn_r;

  always_ff @(posedge clk) begin
    if (a_move) begin
      up_r   <= above_q;
      mid1_r <= mid2_r;
      mid2_r <= cur_q;
      dn_r   <= a_px_r;
    end
  end

  // ---- lanes: one per channel, working on the shifted window ----
  logic [lsh_pkg::NUM_SLOTS-1:0][lsh_pkg::SAMP_W-1:0] lane_res;

  for (genvar k = 0; k < lsh_pkg::NUM_SLOTS; k++) begin : g_lane
    if (k < MAX_CHANNELS) begin : g_on
      lsh_lane u_lane (
        .center (mid2_r[k*lsh_pkg::SAMP_W +: lsh_pkg::SAMP_W]),
        .left   (mid1_r[k*lsh_pkg::SAMP_W +: lsh_pkg::SAMP_W]),
        .right  (cur_q [k*lsh_pkg::SAMP_W +: lsh_pkg::SAMP_W]),
        .up     (up_r  [k*lsh_pkg::SAMP_W +: lsh_pkg::SAMP_W]),
        .down   (dn_r  [k*lsh_pkg::SAMP_W +: lsh_pkg::SAMP_W]),
        .en     (a_int_r && (lsh_pkg::CHAN_W'(k) < ch_eff)),
        .res    (lane_res[k])
      );
    end else begin : g_off
      assign lane_res[k] = '0;
    end
  end

  // ---- merge and result sequencing ----
  lsh_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (a_move && a_emit_r),
    .grp       (a_grp_r),
    .lane_res  (lane_res),
    .ready     (emit_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---- checks ----
  // read and write of the line memories never meet at one column
  a_ram_port_sep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && a_move) |-> (col_r != a_col_r))
    else $error("line memory read and write at the same column");

  // column counter stays inside the effective row
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(col_r) <= w_last)
    else $error("column counter past row end");

  // a group that is not finished keeps its valid
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_of_run) |=> out_valid)
    else $error("result group broken off");

  // with one channel in use the other lanes read zero
  a_chan_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ch_eff == lsh_pkg::CHAN_W'(1)) |->
      (out_data.result_1 == '0 && out_data.result_2 == '0 &&
       out_data.result_3 == '0))
    else $error("unused channel not zero");

endmodule

// File: tb/laplacian_sharpen_3x3_tb.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_tb: self-checking bench for the 3x3 sharpening filter
// Streams raster pixel words through the filter with random source gaps and
// sink stalls. A behavioral copy of the line buffers, window and counters
// predicts every result word. Result words are compared field by field, in
// arrival order, across many frame geometries and channel counts.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  // index past the register list; writes to it must be ignored
  localparam logic [lsh_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  lsh_pkg::in_word_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lsh_pkg::out_word_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  laplacian_sharpen_3x3 #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Filter predictor state: two rows above the incoming row, the 3x3 window
  // (index row*3+col, row 0 oldest line, col 2 newest pixel), raster position
  // of the next pixel and the register copies.
  // --------------------------------------------------------------------------
  logic [31:0] row_m2 [MAX_WIDTH];
  logic [31:0] row_m1 [MAX_WIDTH];
  logic [31:0] win    [9];
  int unsigned cur_row, cur_col;
  logic [11:0] img_width, img_height;
  logic [2:0]  chan_count;

  lsh_pkg::in_word_t  pixel_q[$];          // pixel words waiting for the driver
  lsh_pkg::out_word_t pending_results[$];  // predicted result words, oldest first

  int unsigned errors     = 0;
  int unsigned n_pixels   = 0;
  int unsigned n_results  = 0;
  int unsigned n_settings = 0;

  // idle shaping for both channels
  int unsigned in_gap   = 0;
  int unsigned in_calm  = 0;
  int unsigned out_hold = 0;
  int unsigned out_calm = 0;
  int unsigned roll;

  // geometry as the block uses it: width 3..MAX_WIDTH, height at least 3
  function automatic int unsigned eff_width();
    if (img_width < lsh_pkg::MIN_DIM) return lsh_pkg::MIN_DIM;
    if (img_width > MAX_WIDTH) return MAX_WIDTH;
    return img_width;
  endfunction

  function automatic int unsigned eff_height();
    if (img_height < lsh_pkg::MIN_DIM) return lsh_pkg::MIN_DIM;
    return img_height;
  endfunction

  // zero channels acts as one, anything above the maximum as the maximum
  function automatic int unsigned eff_chans();
    if (chan_count < 1) return 1;
    if (chan_count > MAX_CHANNELS) return MAX_CHANNELS;
    return chan_count;
  endfunction

  function automatic void reset_model();
    foreach (row_m2[i]) begin
      row_m2[i] = '0;
      row_m1[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    cur_row    = 0;
    cur_col    = 0;
    img_width  = lsh_pkg::WIDTH_RST;
    img_height = lsh_pkg::HEIGHT_RST;
    chan_count = lsh_pkg::CHAN_RST;
  endfunction

  // 5*center - left - right - up - down on one channel, clamped to 0..255
  function automatic logic [7:0] sharpen_chan(int k);
    int v;
    v = lsh_pkg::CENTER_GAIN * int'(win[4][8*k +: 8])
        - int'(win[3][8*k +: 8]) - int'(win[5][8*k +: 8])
        - int'(win[1][8*k +: 8]) - int'(win[7][8*k +: 8]);
    if (v < 0) v = 0;
    if (v > lsh_pkg::PIX_MAX) v = lsh_pkg::PIX_MAX;
    return v[7:0];
  endfunction

  function automatic lsh_pkg::out_word_t make_result(int unsigned row, int unsigned col,
                                                     bit interior);
    logic [7:0]         ch [4];
    lsh_pkg::out_word_t o;
    int                 k;
    for (k = 0; k < 4; k++) begin
      ch[k] = (interior && k < eff_chans()) ? sharpen_chan(k) : 8'd0;
    end
    o.result_0    = ch[0];
    o.result_1    = ch[1];
    o.result_2    = ch[2];
    o.result_3    = ch[3];
    o.out_row     = lsh_pkg::ROW_W'(row);
    o.out_col     = lsh_pkg::COL_W'(col);
    o.last_of_run = 1'b0;
    return o;
  endfunction

  // One accepted pixel word: slide the window, queue the result words it
  // causes (up to four on the last column of the last row), update the lines.
  function automatic void sharpen_pixel(lsh_pkg::in_word_t w);
    int unsigned        wd, ht, r, c;
    int                 cnt, k;
    logic [31:0]        px;
    bit                 last_row;
    lsh_pkg::out_word_t grp [4];
    wd  = eff_width();
    ht  = eff_height();
    r   = cur_row;
    c   = cur_col;
    cnt = 0;
    if (c >= wd) c = wd - 1;
    px = {w.sample_3, w.sample_2, w.sample_1, w.sample_0};

    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = row_m2[c];
    win[5] = row_m1[c];
    win[8] = px;

    // row 0 and column 0 only fill the window
    if (r >= 1 && c >= 1) begin
      last_row = (r >= ht - 1);
      grp[cnt] = make_result(r - 1, c - 1, (r >= 2 && c >= 2));
      cnt++;
      if (last_row) begin
        grp[cnt] = make_result(r, c - 1, 1'b0);
        cnt++;
      end
      if (c == wd - 1) begin
        grp[cnt] = make_result(r - 1, c, 1'b0);
        cnt++;
        if (last_row) begin
          grp[cnt] = make_result(r, c, 1'b0);
          cnt++;
        end
      end
      grp[cnt-1].last_of_run = 1'b1;
      for (k = 0; k < cnt; k++) pending_results.push_back(grp[k]);
    end

    row_m2[c] = row_m1[c];
    row_m1[c] = px;

    c++;
    if (c >= wd) begin
      c = 0;
      r++;
      if (r >= ht) r = 0;
    end
    cur_col = c;
    cur_row = r;
  endfunction

  // register copy; a geometry write restarts the frame but keeps the lines
  function automatic void apply_reg(logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lsh_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      lsh_pkg::CFG_IMAGE_WIDTH: begin
        img_width = val;
        cur_row   = 0;
        cur_col   = 0;
      end
      lsh_pkg::CFG_IMAGE_HEIGHT: begin
        img_height = val;
        cur_row    = 0;
        cur_col    = 0;
      end
      lsh_pkg::CFG_CHANNEL_COUNT: begin
        chan_count = val[2:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got,
                                      lsh_pkg::out_word_t ref_w);
    if (got !== want) begin
      $display("%0t: %s at row %0d col %0d: expected %0d, got %0d",
               $time, name, ref_w.out_row, ref_w.out_col, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(lsh_pkg::out_word_t got);
    lsh_pkg::out_word_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with nothing expected: expected none, got row %0d col %0d",
               $time, got.out_row, got.out_col);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    n_results++;
    check_field("result_0",    want.result_0,    got.result_0,    want);
    check_field("result_1",    want.result_1,    got.result_1,    want);
    check_field("result_2",    want.result_2,    got.result_2,    want);
    check_field("result_3",    want.result_3,    got.result_3,    want);
    check_field("out_row",     want.out_row,     got.out_row,     want);
    check_field("out_col",     want.out_col,     got.out_col,     want);
    check_field("last_of_run", want.last_of_run, got.last_of_run, want);
  endfunction

  // mostly short idles, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // "harsh" pixels pin some channels to 0 or 255 so both clamps get hit
  function automatic lsh_pkg::in_word_t rand_pixel(bit harsh);
    logic [31:0] v, m;
    int          k;
    v = $urandom;
    m = $urandom;
    if (harsh) begin
      for (k = 0; k < 4; k++) begin
        if (m[k]) v[8*k +: 8] = {8{m[k+4]}};
      end
    end
    return lsh_pkg::in_word_t'(v);
  endfunction

  function automatic void push_pixels(int unsigned n, bit harsh);
    repeat (n) pixel_q.push_back(rand_pixel(harsh));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents pixel words from pixel_q. A word stays put while
  // stalled; the predictor runs on the word at the edge that accepts it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sharpen_pixel(in_data);
        n_pixels++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pixel_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pixel_q.pop_front();
          // occasional stretch of back-to-back words
          if (in_calm != 0) begin
            in_calm--;
          end else if ($urandom_range(0, 63) == 0) begin
            in_calm = $urandom_range(30, 150);
          end else begin
            in_gap = pick_idle();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every accepted result word and drives random stalls,
  // with calm stretches where the sink takes one word per cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result(out_data);
      if (out_hold != 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else if (out_calm != 0) begin
        out_stall <= 1'b0;
        out_calm--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          out_calm = $urandom_range(30, 150);
          out_stall <= 1'b0;
        end else if (roll < 27) begin
          out_hold = pick_idle();
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes land at the edge after each call; end_writes drops the
  // enable. Only used while the filter is idle.
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                           logic [lsh_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // all words sent and all results back; the extra wait lets a group that
  // produced no result (row 0) leave the pipe too
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned                    frame, n, half, random_items, i, sel;
    bit                             paused;
    logic [lsh_pkg::CFG_DATA_W-1:0] d;
    lsh_pkg::in_word_t              px;

    reset_model();
    random_items = 0;
    paused       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset channel count (three) and reset height on a narrowed frame
    write_reg(lsh_pkg::CFG_IMAGE_WIDTH, 12'd8);
    end_writes();
    push_pixels(4 * 8, 1'b1);
    wait_idle();

    // 3x3 frames, four channels: a single interior pixel each
    write_reg(lsh_pkg::CFG_IMAGE_WIDTH, 12'd3);
    write_reg(lsh_pkg::CFG_IMAGE_HEIGHT, 12'd3);
    write_reg(lsh_pkg::CFG_CHANNEL_COUNT, 12'd4);
    end_writes();
    // bright center on dark edges: clamps high on every channel
    for (i = 0; i < 9; i++) begin
      if (i == 4) px = lsh_pkg::in_word_t'({4{8'hFF}});
      else if (i % 2) px = '0;
      else px = lsh_pkg::in_word_t'({4{8'h55}});
      pixel_q.push_back(px);
    end
    // per channel: clamp low, mid-range, clamp high, small positive
    for (i = 0; i < 9; i++) begin
      if (i == 4) px = lsh_pkg::in_word_t'({8'h00, 8'd100, 8'hFF, 8'h01});
      else if (i % 2) px = lsh_pkg::in_word_t'({8'hFF, 8'd90, 8'h00, 8'h01});
      else px = rand_pixel(1'b0);
      pixel_q.push_back(px);
    end
    wait_idle();

    // out-of-range values: width 1 and height 0 act as 3, channel 0 as 1
    // (junk in the upper data bits), stray write to the unmapped index
    write_reg(lsh_pkg::CFG_IMAGE_WIDTH, 12'd1);
    write_reg(lsh_pkg::CFG_IMAGE_HEIGHT, 12'd0);
    write_reg(lsh_pkg::CFG_CHANNEL_COUNT, 12'hFF8);
    write_reg(CFG_UNMAPPED, lsh_pkg::CFG_DATA_W'($urandom));
    end_writes();
    push_pixels(18, 1'b1);
    wait_idle();
    // channel count 7 acts as 4, width 2 as 3
    write_reg(lsh_pkg::CFG_CHANNEL_COUNT, 12'd7);
    write_reg(lsh_pkg::CFG_IMAGE_WIDTH, 12'd2);
    end_writes();
    push_pixels(18, 1'b1);

    // random phases: mostly whole frames of small geometry, sometimes a
    // partial frame that the next phase continues or restarts
    while (random_items < 380) begin
      wait_idle();
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) d = lsh_pkg::CFG_DATA_W'($urandom_range(0, 2));
        else if (sel == 1) d = lsh_pkg::CFG_DATA_W'($urandom_range(11, 40));
        else d = lsh_pkg::CFG_DATA_W'($urandom_range(3, 10));
        write_reg(lsh_pkg::CFG_IMAGE_WIDTH, d);
      end
      if ($urandom_range(0, 1)) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) d = lsh_pkg::CFG_DATA_W'($urandom_range(0, 2));
        else if (sel == 1) d = lsh_pkg::CFG_DATA_W'($urandom_range(9, 20));
        else d = lsh_pkg::CFG_DATA_W'($urandom_range(3, 8));
        write_reg(lsh_pkg::CFG_IMAGE_HEIGHT, d);
      end
      if ($urandom_range(0, 1)) begin
        d      = lsh_pkg::CFG_DATA_W'($urandom);
        d[2:0] = 3'($urandom_range(0, 7));
        write_reg(lsh_pkg::CFG_CHANNEL_COUNT, d);
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNMAPPED, lsh_pkg::CFG_DATA_W'($urandom));
      end_writes();

      frame = eff_width() * eff_height();
      n     = frame * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, frame - 1);
      // keep the total near the planned item count
      if (n > 380 - random_items) n = 380 - random_items;
      random_items += n;
      if (!paused) begin
        // source holds off mid-frame until every result has drained
        half = n / 2;
        push_pixels(half, 1'b0);
        wait_idle();
        n      -= half;
        paused  = 1'b1;
      end
      push_pixels(n, $urandom_range(0, 3) == 0);
    end
    wait_idle();
    repeat (16) @(posedge clk);

    $display("Sent %0d pixel words, checked %0d result words over %0d register settings",
             n_pixels, n_results, n_settings);
    $display("Covered small and clamped frame sizes, 1..4 channels, clamped values, %s",
             "frame restarts and wraps");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, sized for worst-case stalls and gaps with a wide margin
  initial begin
    #40_000_000;
    $display("%0t: run limit reached, %0d results still expected", $time,
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
